### src/cpf_pkg.sv
package cpf_pkg;

  localparam int unsigned MAX_PAYLOAD = 512;
  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam int unsigned OUTB_DEPTH = 2;
  localparam int unsigned OUTB_PTR_W = $clog2(OUTB_DEPTH);
  localparam int unsigned OUTB_CNT_W = $clog2(OUTB_DEPTH + 1);

  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    BEAT_0 = 3'd0,
    BEAT_1 = 3'd1,
    BEAT_2 = 3'd2,
    BEAT_3 = 3'd3,
    BEAT_4 = 3'd4
  } beat_e;

  typedef struct packed {
    cmd_e             op;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
  } out_t;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### src/cpf_front.sv
module cpf_front import cpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        kind_i,
  input  logic [7:0]  data_type_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  payload_byte_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o
);

  logic [LEN_W-1:0] bytes_left_q, bytes_left_d;
  logic [LEN_W-1:0] len_clamped;
  logic             is_start;

  assign is_start    = (kind_e'(kind_i) == KIND_START);
  assign len_clamped = (payload_length_i > 16'(MAX_PAYLOAD)) ? MAX_LEN
                                                             : payload_length_i[LEN_W-1:0];

  always_comb begin
    bytes_left_d = bytes_left_q;
    cmd_push_o   = 1'b0;
    cmd_o.op     = CMD_DATA;
    cmd_o.data   = payload_byte_i;
    cmd_o.len    = len_clamped;
    cmd_o.last   = (bytes_left_q == LEN_W'(1));
    if (accept_i) begin
      if (is_start) begin
        cmd_push_o   = 1'b1;
        cmd_o.op     = CMD_START;
        cmd_o.data   = data_type_i;
        bytes_left_d = len_clamped;
      end else if (bytes_left_q != '0) begin
        cmd_push_o   = 1'b1;
        bytes_left_d = bytes_left_q - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
    end else begin
      bytes_left_q <= bytes_left_d;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !is_start && bytes_left_q == '0) |-> !cmd_push_o)
    else $error("Stray payload item produced a command.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_left_q <= MAX_LEN)
    else $error("Remaining byte count exceeds the maximum payload.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_push_o && cmd_o.op == CMD_DATA && cmd_o.last) |=> (bytes_left_q == '0))
    else $error("Frame still open after its last payload byte.");
`endif

endmodule

### src/cpf_cmd_queue.sv
module cpf_cmd_queue import cpf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t                  mem_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMDQ_CNT_W-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CMDQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                              : wr_ptr_q + CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                              : rd_ptr_q + CMDQ_PTR_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CMDQ_CNT_W'(CMDQ_DEPTH))
    else $error("Command queue count out of range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("Command pushed into a full queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("Command queue pointers disagree while empty.");
`endif

endmodule

### src/cpf_back.sv
module cpf_back import cpf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] header_marker_i,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output out_t       out_o
);

  beat_e                 beat_q, beat_d;
  logic [7:0]            crc_q, crc_d;
  logic [15:0]           len_ext;
  out_t                  cur;
  logic                  final_beat;
  logic                  emit;
  logic                  out_space;

  out_t                  buf_q [OUTB_DEPTH];
  logic [OUTB_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUTB_CNT_W-1:0] count_q, count_d;
  logic                  do_pop;

  assign len_ext   = 16'(cmd_i.len);
  assign empty_o   = (count_q == '0);
  assign do_pop    = pop_i && !empty_o;
  assign out_space = (count_q != OUTB_CNT_W'(OUTB_DEPTH)) || do_pop;
  assign emit      = cmd_valid_i && out_space;
  assign out_o     = buf_q[rd_ptr_q];

  always_comb begin
    cur.data      = crc_q;
    cur.frame_end = 1'b1;
    final_beat    = 1'b1;
    if (cmd_i.op == CMD_START) begin
      unique case (beat_q)
        BEAT_0: begin
          cur.data      = header_marker_i;
          cur.frame_end = 1'b0;
          final_beat    = 1'b0;
        end
        BEAT_1: begin
          cur.data      = cmd_i.data;
          cur.frame_end = 1'b0;
          final_beat    = 1'b0;
        end
        BEAT_2: begin
          cur.data      = len_ext[15:8];
          cur.frame_end = 1'b0;
          final_beat    = 1'b0;
        end
        BEAT_3: begin
          cur.data      = len_ext[7:0];
          cur.frame_end = 1'b0;
          final_beat    = (cmd_i.len != '0);
        end
        default: begin
          cur.data      = crc_q;
          cur.frame_end = 1'b1;
          final_beat    = 1'b1;
        end
      endcase
    end else begin
      unique case (beat_q)
        BEAT_0: begin
          cur.data      = cmd_i.data;
          cur.frame_end = 1'b0;
          final_beat    = !cmd_i.last;
        end
        default: begin
          cur.data      = crc_q;
          cur.frame_end = 1'b1;
          final_beat    = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    beat_d    = beat_q;
    crc_d     = crc_q;
    cmd_pop_o = 1'b0;
    if (emit) begin
      if (!cur.frame_end) begin
        crc_d = crc8_update((cmd_i.op == CMD_START && beat_q == BEAT_0) ? CRC_INIT : crc_q,
                            cur.data);
      end
      if (final_beat) begin
        beat_d    = BEAT_0;
        cmd_pop_o = 1'b1;
      end else begin
        beat_d = beat_e'(beat_q + 3'd1);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (emit && !do_pop) begin
      count_d = count_q + OUTB_CNT_W'(1);
    end else if (do_pop && !emit) begin
      count_d = count_q - OUTB_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      buf_q[wr_ptr_q] <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q   <= BEAT_0;
      crc_q    <= CRC_INIT;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      beat_q  <= beat_d;
      crc_q   <= crc_d;
      count_q <= count_d;
      if (emit) begin
        wr_ptr_q <= (wr_ptr_q == OUTB_PTR_W'(OUTB_DEPTH - 1)) ? '0
                                                              : wr_ptr_q + OUTB_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == OUTB_PTR_W'(OUTB_DEPTH - 1)) ? '0
                                                              : rd_ptr_q + OUTB_PTR_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OUTB_CNT_W'(OUTB_DEPTH))
    else $error("Output buffer count out of range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && cur.frame_end) |-> cmd_pop_o)
    else $error("Frame end emitted without retiring its command.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_valid_i) |-> (beat_q == BEAT_0))
    else $error("Beat counter advanced with no command pending.");
`endif

endmodule

### src/crc8_packet_framer.sv
// Frames a byte stream: a start item writes the header marker, the type and the clamped
// 16-bit length (big endian), payload items pass their byte through, and a CRC-8 byte
// (polynomial 0x07, initial value 0, MSB first) over header and payload closes each frame
// with frame_end set. A payload item emits its byte, the frame's last one also the CRC;
// a start item emits marker, type and length bytes, plus the CRC for a zero-length frame.
// The back end emits one byte per cycle into a two-entry output buffer while it has room;
// the front end accepts one item per cycle, when not full, into a two-entry command queue,
// so full rises only while the back end works through a multi-byte item or output stalls.
// Payload items with no open frame, or beyond the declared length, are accepted and dropped.
module crc8_packet_framer import cpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [7:0]  data_type_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  payload_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o
);

  logic [7:0] header_marker_q;
  logic       accept;
  logic       cmd_push;
  cmd_t       cmd_in;
  logic       cmdq_full;
  logic       cmd_valid;
  logic       cmd_pop;
  cmd_t       cmd_out;
  out_t       out_item;

  assign full   = cmdq_full;
  assign accept = push && !cmdq_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_marker_q <= '0;
    end else if (cfg_we_i) begin
      header_marker_q <= cfg_wdata_i;
    end
  end

  cpf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .kind_i           (kind_i),
    .data_type_i      (data_type_i),
    .payload_length_i (payload_length_i),
    .payload_byte_i   (payload_byte_i),
    .cmd_push_o       (cmd_push),
    .cmd_o            (cmd_in)
  );

  cpf_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmdq_full),
    .valid_o (cmd_valid),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_out)
  );

  cpf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .header_marker_i (header_marker_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd_out),
    .cmd_pop_o       (cmd_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .out_o           (out_item)
  );

  assign out_byte_o  = out_item.data;
  assign frame_end_o = out_item.frame_end;

endmodule

### dv/crc8_packet_framer_tb.sv
`timescale 1ns / 100ps

module crc8_packet_framer_tb;
  import cpf_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 20;
  localparam int unsigned NUM_PHASES = 5;

  class frame_scoreboard;
    logic [7:0]  marker;
    logic [15:0] left;
    logic [7:0]  crc;
    logic        open;
    out_t        frame_bytes_q[$];
    int          errors;

    function new();
      marker = 8'h00;
      left = 16'd0;
      crc = CRC_INIT;
      open = 1'b0;
      errors = 0;
    endfunction

    function logic [7:0] crc8_next(logic [7:0] c, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ d[i];
        c = {c[6:0], 1'b0};
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    function void add_byte(logic [7:0] b, logic fe);
      out_t r;
      r.data = b;
      r.frame_end = fe;
      frame_bytes_q.push_back(r);
      if (!fe) begin
        crc = crc8_next(crc, b);
      end
    endfunction

    function void note_item(kind_e kind, logic [7:0] dtype, logic [15:0] len,
                            logic [7:0] pbyte);
      logic [15:0] clamped;
      if (kind == KIND_START) begin
        clamped = (len > MAX_PAYLOAD) ? 16'(MAX_PAYLOAD) : len;
        crc = CRC_INIT;
        add_byte(marker, 1'b0);
        add_byte(dtype, 1'b0);
        add_byte(clamped[15:8], 1'b0);
        add_byte(clamped[7:0], 1'b0);
        if (clamped == 16'd0) begin
          add_byte(crc, 1'b1);
          open = 1'b0;
          left = 16'd0;
        end else begin
          open = 1'b1;
          left = clamped;
        end
      end else if (open && left != 16'd0) begin
        add_byte(pbyte, 1'b0);
        left = left - 16'd1;
        if (left == 16'd0) begin
          add_byte(crc, 1'b1);
          open = 1'b0;
        end
      end
    endfunction

    function void check_result(logic [7:0] b, logic fe);
      out_t want;
      if (frame_bytes_q.size() == 0) begin
        errors++;
        $display("%0t: byte with nothing pending: expected none, actual %02h/%0b",
                 $time, b, fe);
        return;
      end
      want = frame_bytes_q.pop_front();
      if (b !== want.data) begin
        errors++;
        $display("%0t: out_byte expected %02h, actual %02h", $time, want.data, b);
      end
      if (fe !== want.frame_end) begin
        errors++;
        $display("%0t: frame_end expected %0b, actual %0b", $time, want.frame_end, fe);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        push;
  logic        full;
  logic        kind_i;
  logic [7:0]  data_type_i;
  logic [15:0] payload_length_i;
  logic [7:0]  payload_byte_i;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte_o;
  logic        frame_end_o;

  frame_scoreboard sb = new();
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned stall_left = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;

  always #2 clk_i = ~clk_i;

  crc8_packet_framer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .push            (push),
    .full            (full),
    .kind_i          (kind_i),
    .data_type_i     (data_type_i),
    .payload_length_i(payload_length_i),
    .payload_byte_i  (payload_byte_i),
    .empty           (empty),
    .pop             (pop),
    .out_byte_o      (out_byte_o),
    .frame_end_o     (frame_end_o)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("crc8_packet_framer: mismatch");
      $finish;
    end
  end

  // The receiver takes a long hold when asked and otherwise, while idle_on is set, stalls in short random bursts.
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        sb.check_result(out_byte_o, frame_end_o);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_item(kind_e kind, logic [7:0] dtype, logic [15:0] len,
                           logic [7:0] pbyte);
    push <= 1'b1;
    kind_i <= kind;
    data_type_i <= dtype;
    payload_length_i <= len;
    payload_byte_i <= pbyte;
    do @(posedge clk_i); while (full);
    sb.note_item(kind, dtype, len, pbyte);
    items_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic send_start(logic [7:0] dtype, logic [15:0] len);
    send_item(KIND_START, dtype, len, 8'($urandom));
  endtask

  task automatic send_payload(logic [7:0] pbyte);
    send_item(KIND_PAYLOAD, 8'($urandom), 16'($urandom), pbyte);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (sb.frame_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_marker(logic [7:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.marker = value;
  endtask

  // Mostly short frames; oversized ones, and a few others, are cut short by the next start.
  task automatic random_frame();
    logic [15:0] len;
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      len = 16'($urandom_range(0, 6));
    end else if (sel < 85) begin
      len = 16'($urandom_range(7, 40));
    end else begin
      len = 16'($urandom);
    end
    n = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : len;
    send_start(8'($urandom), len);
    if (n > 40) begin
      n = $urandom_range(0, 12);
    end else if (n > 0 && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(0, n - 1);
    end
    repeat (n) send_payload(8'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      send_payload(8'($urandom));
    end
  endtask

  initial begin
    int unsigned start_count;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 8'h00;
    push <= 1'b0;
    kind_i <= KIND_START;
    data_type_i <= 8'h00;
    payload_length_i <= 16'h0000;
    payload_byte_i <= 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_marker(8'h00);
    send_item(KIND_PAYLOAD, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(KIND_START, 8'h00, 16'h0000, 8'hFF);
    send_item(KIND_START, 8'hFF, 16'h0002, 8'hFF);
    send_item(KIND_PAYLOAD, 8'hFF, 16'hFFFF, 8'h00);
    send_item(KIND_PAYLOAD, 8'h00, 16'h0000, 8'hFF);
    send_payload(8'hAA);
    send_start(8'h5A, 16'hFFFF);
    send_payload(8'h3C);
    send_payload(8'hC3);
    send_start(8'hA5, 16'd513);
    send_start(8'h7E, 16'd512);
    send_payload(8'h55);
    send_start(8'h01, 16'd1);
    send_payload(8'h80);
    send_start(8'h81, 16'd3);
    send_payload(8'h01);
    send_payload(8'h02);
    send_payload(8'h04);
    send_payload(8'h08);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p == 0) begin
        write_marker(8'hFF);
      end else if (p == NUM_PHASES - 1) begin
        write_marker(8'h00);
      end else begin
        write_marker(8'($urandom));
      end
      idle_on = (p != NUM_PHASES - 1);
      if (p == 1) begin
        hold_req = 1'b1;
      end
      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(kind_e'($urandom_range(0, 1)), 8'($urandom), 16'($urandom),
                    8'($urandom));
        end else begin
          random_frame();
        end
      end
    end
    settle();

    if (sb.errors == 0) begin
      $display("crc8_packet_framer: match");
    end else begin
      $display("crc8_packet_framer: mismatch");
    end
    $finish;
  end

endmodule
